FILE: rtl/rc4_pkg.sv
// Shared constants and inter-module control types for the RC4 keystream cipher.
package rc4_pkg;

  localparam int RC4_MAX_KEY_BYTES = 256;
  localparam int RC4_LEN_W         = 9;

  localparam logic [RC4_LEN_W-1:0] RC4_KEY_LEN_RST = 9'd16;

  // request type codes
  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_DATA = 1'b1;

  // command from the front end to the permutation engine
  typedef struct packed {
    logic                 ks;     // run the key schedule
    logic                 gen;    // generate one keystream byte
    logic                 first;  // restart keystream indices
    logic [7:0]           data;   // data word to encrypt
    logic [RC4_LEN_W-1:0] len;    // effective key length for the schedule
  } rc4_cmd_t;

  // status from the permutation engine
  typedef struct packed {
    logic       idle;
    logic       ks_done;
    logic       out_valid;
    logic [7:0] out_byte;
  } rc4_stat_t;

endpackage

FILE: rtl/rc4_in_if.sv
// Input channel: key or data word with valid/ready handshake.
interface rc4_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] byte_in;
  logic       first_of_message;

  modport source (output valid, req_type, byte_in, first_of_message, input ready);
  modport sink   (input valid, req_type, byte_in, first_of_message, output ready);
endinterface

FILE: rtl/rc4_out_if.sv
// Result channel: processed data word with valid/ready handshake.
interface rc4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       key_missing;

  modport source (output valid, byte_out, key_missing, input ready);
  modport sink   (input valid, byte_out, key_missing, output ready);
endinterface

FILE: rtl/rc4_keymem.sv
// Key store: one write port, one registered read port.
module rc4_keymem #(
  parameter int DEPTH = rc4_pkg::RC4_MAX_KEY_BYTES,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  import rc4_pkg::*;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/rc4_engine.sv
// Permutation memory with key schedule and keystream generator sequencer.
module rc4_engine #(
  parameter int KEY_AW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rc4_pkg::rc4_cmd_t   cmd,
  output rc4_pkg::rc4_stat_t  stat,
  output logic [KEY_AW-1:0]   key_raddr,
  input  logic [7:0]          key_rdata
);
  import rc4_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_FILL    = 4'd1;
  localparam logic [3:0] ST_KS_RD   = 4'd2;
  localparam logic [3:0] ST_KS_CALC = 4'd3;
  localparam logic [3:0] ST_KS_WR_I = 4'd4;
  localparam logic [3:0] ST_KS_WR_J = 4'd5;
  localparam logic [3:0] ST_GEN_J   = 4'd6;
  localparam logic [3:0] ST_GEN_T   = 4'd7;
  localparam logic [3:0] ST_GEN_OUT = 4'd8;

  logic [7:0] perm [256];
  logic [7:0] rd_q;
  logic [7:0] rd_addr;
  logic       we;
  logic [7:0] wa;
  logic [7:0] wd;

  logic [3:0]           state_r, state_nxt;
  logic [7:0]           i_r, i_nxt;
  logic [7:0]           j_r, j_nxt;
  logic [7:0]           si_r, si_nxt;
  logic [7:0]           sj_r, sj_nxt;
  logic [7:0]           t_r, t_nxt;
  logic [7:0]           data_r, data_nxt;
  logic [RC4_LEN_W-1:0] len_r, len_nxt;
  logic [RC4_LEN_W-1:0] kidx_r, kidx_nxt;
  logic [RC4_LEN_W-1:0] kidx_inc;
  logic [7:0]           ks_byte;

  always_ff @(posedge clk) begin
    if (we) begin
      perm[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= perm[rd_addr];
  end

  assign key_raddr = kidx_r[KEY_AW-1:0];
  assign kidx_inc  = kidx_r + 9'd1;

  // S[t] was read before either swap write landed; forward the swapped values
  always_comb begin
    if (t_r == i_r) begin
      ks_byte = sj_r;
    end else if (t_r == j_r) begin
      ks_byte = si_r;
    end else begin
      ks_byte = rd_q;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    si_nxt         = si_r;
    sj_nxt         = sj_r;
    t_nxt          = t_r;
    data_nxt       = data_r;
    len_nxt        = len_r;
    kidx_nxt       = kidx_r;
    rd_addr        = i_r;
    we             = 1'b0;
    wa             = i_r;
    wd             = rd_q;
    stat.idle      = (state_r == ST_IDLE);
    stat.ks_done   = 1'b0;
    stat.out_valid = 1'b0;
    stat.out_byte  = data_r ^ ks_byte;
    case (state_r)
      ST_IDLE: begin
        if (cmd.ks) begin
          i_nxt     = 8'd0;
          j_nxt     = 8'd0;
          kidx_nxt  = '0;
          len_nxt   = cmd.len;
          state_nxt = ST_FILL;
        end else if (cmd.gen) begin
          i_nxt     = (cmd.first ? 8'd0 : i_r) + 8'd1;
          j_nxt     = cmd.first ? 8'd0 : j_r;
          data_nxt  = cmd.data;
          rd_addr   = i_nxt;
          state_nxt = ST_GEN_J;
        end
      end
      ST_FILL: begin
        we    = 1'b1;
        wa    = i_r;
        wd    = i_r;
        i_nxt = i_r + 8'd1;
        if (i_r == 8'hFF) begin
          state_nxt = ST_KS_RD;
        end
      end
      ST_KS_RD: begin
        rd_addr   = i_r;
        state_nxt = ST_KS_CALC;
      end
      ST_KS_CALC: begin
        si_nxt    = rd_q;
        j_nxt     = j_r + rd_q + key_rdata;
        rd_addr   = j_nxt;
        state_nxt = ST_KS_WR_I;
      end
      ST_KS_WR_I: begin
        we        = 1'b1;
        wa        = i_r;
        wd        = rd_q;
        state_nxt = ST_KS_WR_J;
      end
      ST_KS_WR_J: begin
        we       = 1'b1;
        wa       = j_r;
        wd       = si_r;
        i_nxt    = i_r + 8'd1;
        kidx_nxt = (kidx_inc == len_r) ? '0 : kidx_inc;
        if (i_r == 8'hFF) begin
          j_nxt        = 8'd0;
          stat.ks_done = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_KS_RD;
        end
      end
      ST_GEN_J: begin
        si_nxt    = rd_q;
        j_nxt     = j_r + rd_q;
        rd_addr   = j_nxt;
        state_nxt = ST_GEN_T;
      end
      ST_GEN_T: begin
        we        = 1'b1;
        wa        = i_r;
        wd        = rd_q;
        sj_nxt    = rd_q;
        t_nxt     = si_r + rd_q;
        rd_addr   = t_nxt;
        state_nxt = ST_GEN_OUT;
      end
      ST_GEN_OUT: begin
        we             = 1'b1;
        wa             = j_r;
        wd             = si_r;
        stat.out_valid = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= 8'd0;
      j_r     <= 8'd0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    si_r   <= si_nxt;
    sj_r   <= sj_nxt;
    t_r    <= t_nxt;
    data_r <= data_nxt;
    len_r  <= len_nxt;
    kidx_r <= kidx_nxt;
  end

  a_cmd_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ks || cmd.gen) |-> state_r == ST_IDLE)
    else $error("engine command issued while busy");

  a_gen_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.gen && !cmd.ks) |-> ##3 stat.out_valid)
    else $error("keystream result not produced three cycles after start");

  a_ks_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ks |=> state_r == ST_FILL && i_r == 8'd0 && j_r == 8'd0)
    else $error("key schedule did not start from cleared indices");

endmodule

FILE: rtl/rc4_keystream_cipher.sv
// RC4 keystream cipher top level: key loading, configuration and result register.
// Data word: the engine issues the read of S[i], reads S[j], reads S[t] while writing S[i], then
// writes S[j] and gives the result, which is registered; no new word is taken until it is idle.
// Word before any key: passed through with key_missing set, registered in the cycle after acceptance.
// Key word: the last key word starts the schedule (an identity fill, then read, compute-j and two
// swap writes per permutation entry) during which input is held off.
// Reset (rst_n low, synchronous): indices, key count and key-ready cleared, key length 16.
module rc4_keystream_cipher #(
  parameter int MAX_KEY_BYTES = rc4_pkg::RC4_MAX_KEY_BYTES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rc4_in_if.sink                         in_ch,
  rc4_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [rc4_pkg::RC4_LEN_W-1:0]  cfg_wdata
);
  import rc4_pkg::*;

  localparam int                   KEY_AW  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [RC4_LEN_W-1:0] MAX_LEN = RC4_LEN_W'(MAX_KEY_BYTES);

  rc4_cmd_t  cmd;
  rc4_stat_t stat;

  logic [RC4_LEN_W-1:0] key_len_r;
  logic [RC4_LEN_W-1:0] eff_len;
  logic [RC4_LEN_W-1:0] loaded_r, loaded_nxt;
  logic                 key_ready_r, key_ready_nxt;

  logic                 acc;
  logic                 key_acc;
  logic                 data_acc;
  logic [RC4_LEN_W-1:0] kwa;
  logic [RC4_LEN_W-1:0] kwa_inc;
  logic                 trig;

  logic [KEY_AW-1:0]    key_raddr;
  logic [7:0]           key_rdata;

  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic                 out_missing_r;

  // take a word only when the engine is free and the result slot will be empty
  assign in_ch.ready = stat.idle && (!out_valid_r || out_ch.ready);
  assign acc         = in_ch.valid && in_ch.ready;
  assign key_acc     = acc && (in_ch.req_type == REQ_KEY);
  assign data_acc    = acc && (in_ch.req_type == REQ_DATA);

  // clamp the programmed key length into 1..MAX_KEY_BYTES
  always_comb begin
    if (key_len_r == '0) begin
      eff_len = 9'd1;
    end else if (key_len_r > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = key_len_r;
    end
  end

  // first key word restarts loading at position zero
  assign kwa     = in_ch.first_of_message ? '0 : loaded_r;
  assign kwa_inc = kwa + 9'd1;
  assign trig    = (kwa_inc >= eff_len);

  assign cmd.ks    = key_acc && trig;
  assign cmd.gen   = data_acc && key_ready_r;
  assign cmd.first = in_ch.first_of_message;
  assign cmd.data  = in_ch.byte_in;
  assign cmd.len   = eff_len;

  always_comb begin
    loaded_nxt    = loaded_r;
    key_ready_nxt = key_ready_r | stat.ks_done;
    if (key_acc) begin
      // drop the count once the schedule is launched so the next word opens a new key
      loaded_nxt = trig ? '0 : kwa_inc;
    end
  end

  rc4_keymem #(
    .DEPTH (MAX_KEY_BYTES),
    .AW    (KEY_AW)
  ) u_keymem (
    .clk   (clk),
    .we    (key_acc),
    .waddr (kwa[KEY_AW-1:0]),
    .wdata (in_ch.byte_in),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  rc4_engine #(
    .KEY_AW (KEY_AW)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .key_raddr (key_raddr),
    .key_rdata (key_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r   <= RC4_KEY_LEN_RST;
      loaded_r    <= '0;
      key_ready_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        key_len_r <= cfg_wdata;
      end
      loaded_r    <= loaded_nxt;
      key_ready_r <= key_ready_nxt;
      if (stat.out_valid || (data_acc && !key_ready_r)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload: keystream word from the engine, or pass-through without a key
  always_ff @(posedge clk) begin
    if (stat.out_valid) begin
      out_byte_r    <= stat.out_byte;
      out_missing_r <= 1'b0;
    end else if (data_acc && !key_ready_r) begin
      out_byte_r    <= in_ch.byte_in;
      out_missing_r <= 1'b1;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.byte_out    = out_byte_r;
  assign out_ch.key_missing = out_missing_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    stat.out_valid |-> (!out_valid_r || out_ch.ready))
    else $error("engine result would overwrite a pending word");

  a_key_ready_holds: assert property (@(posedge clk) disable iff (!rst_n)
    key_ready_r |=> key_ready_r)
    else $error("key ready dropped after a completed schedule");

  a_passthru_next: assert property (@(posedge clk) disable iff (!rst_n)
    (data_acc && !key_ready_r) |=> (out_valid_r && out_missing_r))
    else $error("pass-through word not registered one cycle after acceptance");

endmodule

FILE: verif/tb_rc4_keystream_cipher.sv
// Self-checking testbench for the RC4 keystream cipher: directed table, then random phases.
`timescale 1ns / 100ps

module tb_rc4_keystream_cipher;
  import rc4_pkg::*;

  localparam int NUM_DIR        = 25;
  localparam int RANDOM_WORDS   = 1300;
  // wait out the schedule that follows the last key word before touching the register
  localparam int SCHEDULE_WAIT  = 1400;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int PRESSURE_AT    = 200;
  localparam int PRESSURE_HOLD  = 400;
  localparam int PRESSURE_ARM   = 16;

  // one input word, with an optional hand-written expectation
  typedef struct packed {
    logic       req;
    logic [7:0] b;
    logic       first;
    logic       fixed;
    logic [7:0] exp_byte;
    logic       exp_miss;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       key_missing;
  } cipher_res_t;

  // Directed table: the reset key length of 16 is in force for the whole table.
  localparam stim_row_t DIRECTED [NUM_DIR] = '{
    // no key yet: data passes through untouched with key_missing set
    '{REQ_DATA, 8'h00, 1'b0, 1'b1, 8'h00, 1'b1},
    '{REQ_DATA, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1},
    '{REQ_DATA, 8'hA5, 1'b0, 1'b1, 8'hA5, 1'b1},
    // start a key, then throw it away by restarting the load
    '{REQ_KEY,  8'h11, 1'b1, 1'b0, 8'h00, 1'b0},
    '{REQ_KEY,  8'h22, 1'b0, 1'b0, 8'h00, 1'b0},
    // full 16-word key at the reset length
    '{REQ_KEY,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{REQ_KEY,  8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{REQ_KEY,  8'h01, 1'b0, 1'b0, 8'h00, 1'b0},
    '{REQ_KEY,  8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
    '{REQ_KEY,  8'h7F, 1'b0, 1'b0, 8'h00, 1'b0},
    '{REQ_KEY,  8'hFE, 1'b0, 1'b0, 8'h00, 1'b0},
    '{REQ_KEY,  8'h55, 1'b0, 1'b0, 8'h00, 1'b0},
    '{REQ_KEY,  8'hAA, 1'b0, 1'b0, 8'h00, 1'b0},
    '{REQ_KEY,  8'h12, 1'b0, 1'b0, 8'h00, 1'b0},
    '{REQ_KEY,  8'h34, 1'b0, 1'b0, 8'h00, 1'b0},
    '{REQ_KEY,  8'h56, 1'b0, 1'b0, 8'h00, 1'b0},
    '{REQ_KEY,  8'h78, 1'b0, 1'b0, 8'h00, 1'b0},
    '{REQ_KEY,  8'h9A, 1'b0, 1'b0, 8'h00, 1'b0},
    '{REQ_KEY,  8'hBC, 1'b0, 1'b0, 8'h00, 1'b0},
    '{REQ_KEY,  8'hDE, 1'b0, 1'b0, 8'h00, 1'b0},
    '{REQ_KEY,  8'hF0, 1'b0, 1'b0, 8'h00, 1'b0},
    // data under the fresh key; the last word restarts the indices
    '{REQ_DATA, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{REQ_DATA, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{REQ_DATA, 8'h5A, 1'b0, 1'b0, 8'h00, 1'b0},
    '{REQ_DATA, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [RC4_LEN_W-1:0] cfg_wdata;

  rc4_in_if  in_ch ();
  rc4_out_if out_ch ();

  rc4_keystream_cipher u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: our own copy of the permutation, key store, indices and register.
  logic [7:0]           sbox    [256];
  logic [7:0]           key_mem [256];
  logic [7:0]           ks_i;
  logic [7:0]           ks_j;
  logic [8:0]           key_cnt;
  logic                 key_ok;
  logic [RC4_LEN_W-1:0] key_len_cfg;

  cipher_res_t cipher_bytes_due [$];
  int          words_sent;
  int          results_seen;
  int          err_count;
  int          quiet_cycles;
  bit          src_idle;
  bit          snk_idle;

  // Clamp the register to the usable key length: zero acts as one, saturate at the maximum.
  function automatic int unsigned eff_key_len(input logic [RC4_LEN_W-1:0] v);
    if (v == '0) return 1;
    if (v > RC4_MAX_KEY_BYTES) return RC4_MAX_KEY_BYTES;
    return int'(v);
  endfunction

  // Build the permutation from the identity, cycling the stored key over 256 positions.
  function automatic void run_key_schedule(input int unsigned len);
    logic [7:0] j;
    logic [7:0] tmp;
    int         n;
    j = 8'd0;
    for (n = 0; n < 256; n++) sbox[n] = n[7:0];
    for (n = 0; n < 256; n++) begin
      j = j + sbox[n] + key_mem[n % len];
      tmp = sbox[n];
      sbox[n] = sbox[j];
      sbox[j] = tmp;
    end
    ks_i = 8'd0;
    ks_j = 8'd0;
    key_ok = 1'b1;
  endfunction

  // Advance the predictor by one accepted word; return 1 when the word yields a result.
  function automatic bit predict_cipher_word(input logic req, input logic [7:0] b,
                                             input logic first, output cipher_res_t res);
    int unsigned len;
    logic [7:0]  tmp;
    logic [7:0]  t;
    res = '0;
    if (req == REQ_KEY) begin
      len = eff_key_len(key_len_cfg);
      if (first) key_cnt = 9'd0;
      key_mem[key_cnt[7:0]] = b;
      key_cnt = key_cnt + 9'd1;
      // a shortened length fires the schedule on the next key word
      if (key_cnt >= len) begin
        run_key_schedule(len);
        key_cnt = 9'd0;
      end
      return 1'b0;
    end
    if (!key_ok) begin
      res.byte_out    = b;
      res.key_missing = 1'b1;
      return 1'b1;
    end
    if (first) begin
      ks_i = 8'd0;
      ks_j = 8'd0;
    end
    ks_i = ks_i + 8'd1;
    ks_j = ks_j + sbox[ks_i];
    tmp = sbox[ks_i];
    sbox[ks_i] = sbox[ks_j];
    sbox[ks_j] = tmp;
    t = sbox[ks_i] + sbox[ks_j];
    res.byte_out    = b ^ sbox[t];
    res.key_missing = 1'b0;
    return 1'b1;
  endfunction

  function automatic stim_row_t make_word(input logic req, input logic [7:0] b,
                                          input logic first);
    stim_row_t row;
    row = '0;
    row.req   = req;
    row.b     = b;
    row.first = first;
    return row;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH result %0d %s: got 0x%0h want 0x%0h", results_seen, what, got, want);
    err_count++;
  endtask

  // Offer one word after a random gap, hold it until accepted, then predict its result.
  task automatic send_word(input stim_row_t row);
    int unsigned gap;
    cipher_res_t res;
    gap = src_idle ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.req_type         <= row.req;
    in_ch.byte_in          <= row.b;
    in_ch.first_of_message <= row.first;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    if (predict_cipher_word(row.req, row.b, row.first, res)) begin
      // table rows with a typed-in answer override the prediction
      if (row.fixed) begin
        res.byte_out    = row.exp_byte;
        res.key_missing = row.exp_miss;
      end
      cipher_bytes_due.push_back(res);
    end
  endtask

  task automatic write_key_length(input logic [RC4_LEN_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    key_len_cfg = v;
  endtask

  // One random phase: drain, let any schedule finish, set the key length, then send words.
  task automatic run_phase(input int ph);
    logic [RC4_LEN_W-1:0] cfg_val;
    int unsigned          klen;
    int unsigned          tail;
    int unsigned          mlen;
    bit                   noisy;
    bit                   cont;
    int                   k;
    int                   m;
    in_ch.valid <= 1'b0;
    while (cipher_bytes_due.size() != 0) @(posedge clk);
    repeat (SCHEDULE_WAIT) @(posedge clk);
    // first phases hit the extremes: maximum, above maximum, zero, one,
    // then a partial key left behind and a shorter length that completes it
    case (ph)
      0:       cfg_val = 9'd256;
      1:       cfg_val = 9'd511;
      2:       cfg_val = 9'd0;
      3:       cfg_val = 9'd1;
      4:       cfg_val = 9'd12;
      5:       cfg_val = 9'd3;
      default: cfg_val = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(17, 40))
                                                     : 9'($urandom_range(1, 12));
    endcase
    write_key_length(cfg_val);
    klen     = eff_key_len(cfg_val);
    src_idle = ($urandom_range(0, 3) != 0);
    snk_idle = ($urandom_range(0, 3) != 0);
    noisy    = (ph >= 6) && ($urandom_range(0, 4) == 0);
    cont     = (ph == 5) || ((ph >= 6) && ($urandom_range(0, 3) == 0));
    if (ph == 4) tail = 5;
    else if (ph >= 6 && $urandom_range(0, 3) == 0) tail = $urandom_range(1, 4);
    else tail = 0;

    if (noisy) begin
      // unstructured words: mixed key and data, stray restarts
      repeat ($urandom_range(5, 20))
        send_word(make_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                            $urandom_range(0, 3) == 0));
    end else begin
      // key, optionally continuing a load left over from the last phase
      for (k = 0; k < int'(klen); k++)
        send_word(make_word(REQ_KEY, 8'($urandom_range(0, 255)), (k == 0) && !cont));
      repeat ($urandom_range(1, 3)) begin
        mlen = $urandom_range(1, 12);
        for (m = 0; m < int'(mlen); m++)
          send_word(make_word(REQ_DATA, 8'($urandom_range(0, 255)),
                              (m == 0) && ($urandom_range(0, 3) != 0)));
      end
      // start a new key and leave it unfinished; the old permutation stays live
      for (k = 0; k < int'(tail); k++)
        send_word(make_word(REQ_KEY, 8'($urandom_range(0, 255)), k == 0));
    end
  endtask

  // Result side: random stall per word, one long hold-off to back up the input.
  initial begin : result_sink
    int unsigned stall;
    cipher_res_t want;
    int          waited;
    bit          pressure_done;
    pressure_done = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = snk_idle ? $urandom_range(0, 9) : 0;
      if (!pressure_done && results_seen >= PRESSURE_AT) begin
        // hold off while a word waits and the sender keeps offering; retry later if idle
        out_ch.ready <= 1'b0;
        waited = 0;
        do begin
          @(posedge clk);
          waited++;
        end while (!(out_ch.valid && in_ch.valid) && waited < PRESSURE_ARM);
        if (out_ch.valid && in_ch.valid) begin
          repeat (PRESSURE_HOLD) @(posedge clk);
          pressure_done = 1'b1;
        end
      end else if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      results_seen++;
      if (cipher_bytes_due.size() == 0) begin
        report_mismatch("unexpected word", out_ch.byte_out, 0);
      end else begin
        want = cipher_bytes_due.pop_front();
        if (out_ch.byte_out !== want.byte_out)
          report_mismatch("byte_out", out_ch.byte_out, want.byte_out);
        if (out_ch.key_missing !== want.key_missing)
          report_mismatch("key_missing", out_ch.key_missing, want.key_missing);
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int ph;
    rst_n                  <= 1'b0;
    cfg_we                 <= 1'b0;
    cfg_wdata              <= '0;
    in_ch.valid            <= 1'b0;
    in_ch.req_type         <= REQ_KEY;
    in_ch.byte_in          <= 8'h00;
    in_ch.first_of_message <= 1'b0;
    words_sent   = 0;
    results_seen = 0;
    err_count    = 0;
    ks_i         = 8'd0;
    ks_j         = 8'd0;
    key_cnt      = 9'd0;
    key_ok       = 1'b0;
    key_len_cfg  = RC4_KEY_LEN_RST;
    src_idle     = 1'b1;
    snk_idle     = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table at the reset key length
    foreach (DIRECTED[k]) send_word(DIRECTED[k]);

    ph = 0;
    while (words_sent < NUM_DIR + RANDOM_WORDS) begin
      run_phase(ph);
      ph++;
    end

    // drain, then give a trailing schedule time to finish before the final check
    in_ch.valid <= 1'b0;
    while (cipher_bytes_due.size() != 0) @(posedge clk);
    repeat (SCHEDULE_WAIT) @(posedge clk);
    if (cipher_bytes_due.size() != 0)
      report_mismatch("words never produced", 0, cipher_bytes_due.size());

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
